@@ sv/tsuv_pkg.sv @@
package tsuv_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int UV_FRAC_BITS  = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int ISQRT_STAGES  = 32;

  localparam int UV_W  = UV_FRAC_BITS + 1;
  localparam int REG_W = 17;
  localparam int NW    = 33;
  localparam int CW    = 36;
  localparam int PH_W  = 32;
  localparam int SQ_W  = 64;
  localparam int NORM_TOP = 30;

  // pipeline depths
  localparam int NORM_LAT   = 2;
  localparam int U_LAT      = 1 + CORDIC_STAGES;
  localparam int V_LAT      = 2 + ISQRT_STAGES + 1 + CORDIC_STAGES;
  localparam int U_DELAY    = V_LAT - U_LAT;
  localparam int VERTEX_LAT = NORM_LAT + V_LAT + 1;
  localparam int TOTAL_LAT  = VERTEX_LAT + 1;

  localparam logic [UV_W-1:0] UV_HALF = UV_W'(1) << (UV_FRAC_BITS - 1);
  localparam logic [UV_W-1:0] UV_ONE  = UV_W'(1) << UV_FRAC_BITS;

  // register indexes
  localparam logic [7:0] REG_SEAM_LOW_THR  = 8'd0;
  localparam logic [7:0] REG_SEAM_HIGH_THR = 8'd1;
  localparam logic [7:0] REG_SEAM_HIGH_VAL = 8'd2;
  localparam logic [7:0] REG_SEAM_LOW_VAL  = 8'd3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [PH_W-1:0]      ph;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
  } isqrt_t;

  typedef struct packed {
    logic [REG_W-1:0] low_thr;
    logic [REG_W-1:0] high_thr;
    logic [REG_W-1:0] high_val;
    logic [REG_W-1:0] low_val;
  } seam_cfg_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [PH_W-1:0] atan_turn(input logic [4:0] k);
    logic [PH_W-1:0] r;
    case (k)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/tsuv_cordic_cell.sv @@
module tsuv_cordic_cell (
  input  logic             clk,
  input  logic [4:0]       k,
  input  tsuv_pkg::cordic_t d_in,
  output tsuv_pkg::cordic_t d_out
);
  import tsuv_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  cordic_t              nxt;

  // one vectoring micro-rotation, shifts round toward minus infinity
  always_comb begin
    dx = d_in.y >>> k;
    dy = d_in.x >>> k;
    if (!d_in.y[CW-1]) begin
      nxt.x  = d_in.x + dx;
      nxt.y  = d_in.y - dy;
      nxt.ph = d_in.ph + atan_turn(k);
    end else begin
      nxt.x  = d_in.x - dx;
      nxt.y  = d_in.y + dy;
      nxt.ph = d_in.ph - atan_turn(k);
    end
  end

  always_ff @(posedge clk) begin
    d_out <= nxt;
  end

endmodule

@@ sv/tsuv_isqrt_cell.sv @@
module tsuv_isqrt_cell (
  input  logic            clk,
  input  logic [5:0]      bpos,
  input  tsuv_pkg::isqrt_t d_in,
  output tsuv_pkg::isqrt_t d_out
);
  import tsuv_pkg::*;

  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;
  isqrt_t          nxt;

  // one root bit per cell
  always_comb begin
    bitv  = SQ_W'(1) << bpos;
    trial = d_in.res + bitv;
    if (d_in.n >= trial) begin
      nxt.n   = d_in.n - trial;
      nxt.res = (d_in.res >> 1) + bitv;
    end else begin
      nxt.n   = d_in.n;
      nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    d_out <= nxt;
  end

endmodule

@@ sv/tsuv_vertex.sv @@
module tsuv_vertex (
  input  logic                                    clk,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] x,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] y,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] z,
  output logic [tsuv_pkg::UV_W-1:0]               u,
  output logic [tsuv_pkg::UV_W-1:0]               v,
  output logic                                    zero
);
  import tsuv_pkg::*;

  localparam logic [32:0] U_RND = 33'(1) << (31 - UV_FRAC_BITS);
  localparam logic [32:0] V_RND = 33'(1) << (30 - UV_FRAC_BITS);

  // normalize: magnitudes and largest one
  logic [COORD_WIDTH-1:0]        ax0, ay0, az0, m0;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1;
  logic [COORD_WIDTH-1:0]        m1;

  always_comb begin
    ax0 = x[COORD_WIDTH-1] ? COORD_WIDTH'(-x) : COORD_WIDTH'(x);
    ay0 = y[COORD_WIDTH-1] ? COORD_WIDTH'(-y) : COORD_WIDTH'(y);
    az0 = z[COORD_WIDTH-1] ? COORD_WIDTH'(-z) : COORD_WIDTH'(z);
    m0  = ax0;
    if (ay0 > m0) m0 = ay0;
    if (az0 > m0) m0 = az0;
  end

  always_ff @(posedge clk) begin
    x1 <= x;
    y1 <= y;
    z1 <= z;
    m1 <= m0;
  end

  // normalize: shift so the largest magnitude lands in [2^30, 2^31)
  logic [4:0]           msb;
  logic [4:0]           sh;
  logic signed [NW-1:0] xe, ye, ze;
  logic signed [NW-1:0] xs, ys, zs;
  logic                 zero2, pole2;

  always_comb begin
    msb = '0;
    for (int i = 0; i < COORD_WIDTH; i++) begin
      if (m1[i]) msb = 5'(i);
    end
    sh = 5'(NORM_TOP) - msb;
    xe = {{(NW-COORD_WIDTH){x1[COORD_WIDTH-1]}}, x1};
    ye = {{(NW-COORD_WIDTH){y1[COORD_WIDTH-1]}}, y1};
    ze = {{(NW-COORD_WIDTH){z1[COORD_WIDTH-1]}}, z1};
  end

  always_ff @(posedge clk) begin
    xs    <= xe <<< sh;
    ys    <= ye <<< sh;
    zs    <= ze <<< sh;
    zero2 <= (m1 == '0);
    pole2 <= (x1 == '0) && (z1 == '0);
  end

  // u path: half-plane fold then cordic chain on (-z, -x)
  cordic_t              u_chain [0:CORDIC_STAGES];
  logic signed [CW-1:0] ux0, uy0;

  always_comb begin
    ux0 = -CW'(zs);
    uy0 = -CW'(xs);
  end

  always_ff @(posedge clk) begin
    if (ux0[CW-1]) begin
      u_chain[0].x  <= -ux0;
      u_chain[0].y  <= -uy0;
      u_chain[0].ph <= 32'h8000_0000;
    end else begin
      u_chain[0].x  <= ux0;
      u_chain[0].y  <= uy0;
      u_chain[0].ph <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_ucell
    tsuv_cordic_cell u_cell (
      .clk   (clk),
      .k     (5'(i)),
      .d_in  (u_chain[i]),
      .d_out (u_chain[i+1])
    );
  end

  // line up the u phase with the v path
  logic [PH_W-1:0] u_dly [0:U_DELAY-1];

  always_ff @(posedge clk) begin
    u_dly[0] <= u_chain[CORDIC_STAGES].ph;
    for (int i = 1; i < U_DELAY; i++) begin
      u_dly[i] <= u_dly[i-1];
    end
  end

  // v path: squares of the horizontal components
  logic [31:0]     hx, hz;
  logic [SQ_W-1:0] xsq, zsq;
  logic [SQ_W-1:0] hsum;

  always_comb begin
    hx = xs[NW-1] ? 32'(-xs) : 32'(xs);
    hz = zs[NW-1] ? 32'(-zs) : 32'(zs);
  end

  always_ff @(posedge clk) begin
    xsq  <= SQ_W'(hx) * SQ_W'(hx);
    zsq  <= SQ_W'(hz) * SQ_W'(hz);
    hsum <= xsq + zsq;
  end

  // y rides along the squaring and root stages
  localparam int Y_DELAY = 2 + ISQRT_STAGES;
  logic signed [NW-1:0] y_dly [0:Y_DELAY-1];

  always_ff @(posedge clk) begin
    y_dly[0] <= ys;
    for (int i = 1; i < Y_DELAY; i++) begin
      y_dly[i] <= y_dly[i-1];
    end
  end

  // horizontal length, one root bit per cell
  isqrt_t sq_chain [0:ISQRT_STAGES];

  always_comb begin
    sq_chain[0].n   = hsum;
    sq_chain[0].res = '0;
  end

  for (genvar i = 0; i < ISQRT_STAGES; i++) begin : g_qcell
    tsuv_isqrt_cell q_cell (
      .clk   (clk),
      .bpos  (6'(62 - 2 * i)),
      .d_in  (sq_chain[i]),
      .d_out (sq_chain[i+1])
    );
  end

  // elevation angle from (h, y); h is never negative
  cordic_t v_chain [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    v_chain[0].x  <= CW'(sq_chain[ISQRT_STAGES].res);
    v_chain[0].y  <= CW'(y_dly[Y_DELAY-1]);
    v_chain[0].ph <= '0;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vcell
    tsuv_cordic_cell v_cell (
      .clk   (clk),
      .k     (5'(i)),
      .d_in  (v_chain[i]),
      .d_out (v_chain[i+1])
    );
  end

  // flags follow the v path
  localparam int F_DELAY = V_LAT;
  logic zero_dly [0:F_DELAY-1];
  logic pole_dly [0:F_DELAY-1];

  always_ff @(posedge clk) begin
    zero_dly[0] <= zero2;
    pole_dly[0] <= pole2;
    for (int i = 1; i < F_DELAY; i++) begin
      zero_dly[i] <= zero_dly[i-1];
      pole_dly[i] <= pole_dly[i-1];
    end
  end

  // final scaling, rounding and clamping
  logic [PH_W-1:0]    ut;
  logic [32:0]        usum;
  logic signed [33:0] w;
  logic [31:0]        wc;
  logic [32:0]        vsum;
  logic [UV_W-1:0]    u_next, v_next;

  always_comb begin
    ut   = u_dly[U_DELAY-1] + 32'h8000_0000;
    usum = 33'(ut) + U_RND;
    w    = 34'(signed'(v_chain[CORDIC_STAGES].ph)) + 34'sd1073741824;
    if (w < 0) begin
      wc = '0;
    end else if (w > 34'sd2147483648) begin
      wc = 32'h8000_0000;
    end else begin
      wc = w[31:0];
    end
    vsum   = 33'(wc) + V_RND;
    u_next = pole_dly[F_DELAY-1] ? '0 : usum[32-UV_FRAC_BITS +: UV_W];
    v_next = vsum[31-UV_FRAC_BITS +: UV_W];
    if (zero_dly[F_DELAY-1]) begin
      u_next = UV_HALF;
      v_next = UV_HALF;
    end
  end

  always_ff @(posedge clk) begin
    u    <= u_next;
    v    <= v_next;
    zero <= zero_dly[F_DELAY-1];
  end

endmodule

@@ sv/tsuv_seam.sv @@
module tsuv_seam (
  input  logic                        clk,
  input  tsuv_pkg::seam_cfg_t         cfg,
  input  logic [tsuv_pkg::UV_W-1:0]   u_a,
  input  logic [tsuv_pkg::UV_W-1:0]   u_b,
  input  logic [tsuv_pkg::UV_W-1:0]   u_c,
  input  logic [tsuv_pkg::UV_W-1:0]   v_a,
  input  logic [tsuv_pkg::UV_W-1:0]   v_b,
  input  logic [tsuv_pkg::UV_W-1:0]   v_c,
  input  logic                        z_a,
  input  logic                        z_b,
  input  logic                        z_c,
  output logic [tsuv_pkg::UV_W-1:0]   o_u_a,
  output logic [tsuv_pkg::UV_W-1:0]   o_u_b,
  output logic [tsuv_pkg::UV_W-1:0]   o_u_c,
  output logic [tsuv_pkg::UV_W-1:0]   o_v_a,
  output logic [tsuv_pkg::UV_W-1:0]   o_v_b,
  output logic [tsuv_pkg::UV_W-1:0]   o_v_c,
  output logic                        o_zero
);
  import tsuv_pkg::*;

  logic lo_a, lo_b, lo_c, hi_a, hi_b, hi_c;
  logic [UV_W-1:0] nu_a, nu_b, nu_c;

  // first matching seam pattern wins
  always_comb begin
    lo_a = u_a < cfg.low_thr;
    lo_b = u_b < cfg.low_thr;
    lo_c = u_c < cfg.low_thr;
    hi_a = u_a > cfg.high_thr;
    hi_b = u_b > cfg.high_thr;
    hi_c = u_c > cfg.high_thr;
    nu_a = u_a;
    nu_b = u_b;
    nu_c = u_c;
    if (lo_a && hi_b && hi_c) begin
      nu_a = cfg.high_val;
    end else if (lo_b && hi_a && hi_c) begin
      nu_b = cfg.high_val;
    end else if (lo_c && hi_a && hi_b) begin
      nu_c = cfg.high_val;
    end else if (hi_a && lo_b && lo_c) begin
      nu_a = cfg.low_val;
    end else if (hi_b && lo_a && lo_c) begin
      nu_b = cfg.low_val;
    end else if (hi_c && lo_a && lo_b) begin
      nu_c = cfg.low_val;
    end
  end

  always_ff @(posedge clk) begin
    o_u_a  <= nu_a;
    o_u_b  <= nu_b;
    o_u_c  <= nu_c;
    o_v_a  <= v_a;
    o_v_b  <= v_b;
    o_v_c  <= v_c;
    o_zero <= z_a | z_b | z_c;
  end

endmodule

@@ sv/triangle_sphere_uv_mapping.sv @@
// stages from start to the done strobe: normalize 2, squares 2, root chain 32,
// elevation cordic chain 19, final 1, seam fix 1
// throughput: one triangle per cycle, busy stays low; done cannot be stalled
// reset (rst, synchronous): clears the in-flight valid bits and restores the
// seam registers to 0.2, 0.8, 0.99 and 0.0
module triangle_sphere_uv_mapping (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_a_x,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_a_y,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_a_z,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_b_x,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_b_y,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_b_z,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_c_x,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_c_y,
  input  logic signed [tsuv_pkg::COORD_WIDTH-1:0] vertex_c_z,
  output logic                                    done,
  output logic [tsuv_pkg::UV_W-1:0]               vertex_a_u,
  output logic [tsuv_pkg::UV_W-1:0]               vertex_a_v,
  output logic [tsuv_pkg::UV_W-1:0]               vertex_b_u,
  output logic [tsuv_pkg::UV_W-1:0]               vertex_b_v,
  output logic [tsuv_pkg::UV_W-1:0]               vertex_c_u,
  output logic [tsuv_pkg::UV_W-1:0]               vertex_c_v,
  output logic                                    zero_length_flag,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [7:0]                              cfg_index,
  input  logic [tsuv_pkg::REG_W-1:0]              cfg_data
);
  import tsuv_pkg::*;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // seam registers
  seam_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_thr  <= 17'd13107;
      cfg.high_thr <= 17'd52429;
      cfg.high_val <= 17'd64881;
      cfg.low_val  <= 17'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEAM_LOW_THR:  cfg.low_thr  <= cfg_data;
        REG_SEAM_HIGH_THR: cfg.high_thr <= cfg_data;
        REG_SEAM_HIGH_VAL: cfg.high_val <= cfg_data;
        REG_SEAM_LOW_VAL:  cfg.low_val  <= cfg_data;
        default: ;
      endcase
    end
  end

  // item valid bits along the pipeline
  logic vld [0:TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i < TOTAL_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign done = vld[TOTAL_LAT-1];

  // one mapping pipeline per vertex
  logic [UV_W-1:0] ua, ub, uc, va, vb, vc;
  logic            za, zb, zc;

  tsuv_vertex u_vtx_a (
    .clk (clk), .x (vertex_a_x), .y (vertex_a_y), .z (vertex_a_z),
    .u (ua), .v (va), .zero (za)
  );

  tsuv_vertex u_vtx_b (
    .clk (clk), .x (vertex_b_x), .y (vertex_b_y), .z (vertex_b_z),
    .u (ub), .v (vb), .zero (zb)
  );

  tsuv_vertex u_vtx_c (
    .clk (clk), .x (vertex_c_x), .y (vertex_c_y), .z (vertex_c_z),
    .u (uc), .v (vc), .zero (zc)
  );

  // seam fix-up and output register
  tsuv_seam u_seam (
    .clk    (clk),
    .cfg    (cfg),
    .u_a    (ua),
    .u_b    (ub),
    .u_c    (uc),
    .v_a    (va),
    .v_b    (vb),
    .v_c    (vc),
    .z_a    (za),
    .z_b    (zb),
    .z_c    (zc),
    .o_u_a  (vertex_a_u),
    .o_u_b  (vertex_b_u),
    .o_u_c  (vertex_c_u),
    .o_v_a  (vertex_a_v),
    .o_v_b  (vertex_b_v),
    .o_v_c  (vertex_c_v),
    .o_zero (zero_length_flag)
  );

endmodule

@@ sv/tsuv_checker.sv @@
module tsuv_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [tsuv_pkg::UV_W-1:0]   vertex_a_v,
  input logic [tsuv_pkg::UV_W-1:0]   vertex_b_v,
  input logic [tsuv_pkg::UV_W-1:0]   vertex_c_v,
  input logic [tsuv_pkg::UV_W-1:0]   vertex_a_u
);
  import tsuv_pkg::*;

  // every result traces back to an item taken a fixed time earlier
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without matching item");

  // an item taken with no reset in between comes out on time
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##TOTAL_LAT done)
    else $error("item lost");

  // elevation, and the u of vertex a, never leave the unit range
  a_v_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (vertex_a_v <= UV_ONE) && (vertex_b_v <= UV_ONE) && (vertex_c_v <= UV_ONE)
      && (vertex_a_u <= UV_ONE))
    else $error("uv out of range");

endmodule

bind triangle_sphere_uv_mapping tsuv_checker u_tsuv_checker (.*);
